FILE: rtl/rtcp_pkg.sv
// rtcp_pkg: widths, scale constants and the reciprocal table for the
// rgb to cmyk percentage converter
// no dependencies
package rtcp_pkg;

    localparam int CHAN_W     = 8;
    localparam int PCT_W      = 15;
    localparam int RECIP_W    = 31;
    localparam int FRAC_SHIFT = 16;
    localparam int PROD_W     = CHAN_W + RECIP_W;
    localparam int TBL_DEPTH  = 1 << CHAN_W;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [31:0]       PCT_SCALE  = 32'd25600;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [PCT_W-1:0]   pct_t;
    typedef logic [RECIP_W-1:0] recip_t;
    typedef recip_t recip_tbl_t [TBL_DEPTH];

    // ceil(25600 * 2^16 / m) for every divisor, zero for m = 0
    // d * entry >> 16 equals floor(d * 25600 / m) exactly while d * m < 2^16
    function automatic recip_tbl_t build_recip_tbl();
        recip_tbl_t  tbl;
        logic [31:0] num;
        logic [31:0] quo;
        logic [8:0]  rem;
        logic [8:0]  dvs;
        tbl[0] = '0;
        for (int m = 1; m < TBL_DEPTH; m++)
        begin
            dvs = 9'(m);
            num = (PCT_SCALE << FRAC_SHIFT) + 32'(m - 1);
            quo = '0;
            rem = '0;
            // restoring long division, one bit per step
            for (int i = 31; i >= 0; i--)
            begin
                rem = {rem[7:0], num[i]};
                if (rem >= dvs)
                begin
                    rem    = rem - dvs;
                    quo[i] = 1'b1;
                end
            end
            tbl[m] = quo[RECIP_W-1:0];
        end
        return tbl;
    endfunction

    localparam recip_tbl_t RECIP_TBL = build_recip_tbl();

    // scale factor for division by full scale
    localparam recip_t FULL_RECIP = RECIP_TBL[FULL_SCALE];

endpackage

FILE: rtl/rtcp_if.sv
// rtcp_if: valid/ready channels for pixels in and percentages out
// depends on rtcp_pkg
interface rtcp_pixel_if;
    logic            valid;
    logic            ready;
    rtcp_pkg::chan_t red;
    rtcp_pkg::chan_t green;
    rtcp_pkg::chan_t blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rtcp_pct_if;
    logic           valid;
    logic           ready;
    rtcp_pkg::pct_t cyan_pct;
    rtcp_pkg::pct_t magenta_pct;
    rtcp_pkg::pct_t yellow_pct;
    rtcp_pkg::pct_t black_pct;
    rtcp_pkg::pct_t white_pct;

    modport source (output valid, output cyan_pct, output magenta_pct, output yellow_pct,
                    output black_pct, output white_pct, input ready);
    modport sink   (input valid, input cyan_pct, input magenta_pct, input yellow_pct,
                    input black_pct, input white_pct, output ready);
endinterface

FILE: rtl/rgb_to_cmyk_percent.sv
// rgb_to_cmyk_percent: rgb pixel to cmyk and white percentages, 8 fraction bits
// a request passes stage 1, stage 2, share product and share result registers
// throughput: one pixel per cycle unless the output stalls
// a stalled output holds the whole pipeline, nothing lost or repeated
// reset clears the stage valid bits only; depends on rtcp_pkg, rtcp_if, rtcp_share
module rgb_to_cmyk_percent (
    input  logic clk,
    input  logic rst_n,
    rtcp_pixel_if.sink pix,
    rtcp_pct_if.source pct
);
    import rtcp_pkg::*;

    logic   adv;
    logic   v1_reg;
    logic   v2_reg;
    logic   v3_reg;
    logic   v4_reg;
    chan_t  top_next;
    chan_t  red1_reg;
    chan_t  green1_reg;
    chan_t  blue1_reg;
    chan_t  top1_reg;
    chan_t  dc2_reg;
    chan_t  dm2_reg;
    chan_t  dy2_reg;
    chan_t  dk2_reg;
    chan_t  top2_reg;
    recip_t recip2_reg;
    pct_t   cyan_w;
    pct_t   magenta_w;
    pct_t   yellow_w;
    pct_t   black_w;
    pct_t   white_w;

    // whole pipeline moves unless the output holds an untaken result
    assign adv       = !v4_reg || pct.ready;
    assign pix.ready = adv;

    // largest channel
    always_comb
    begin
        top_next = pix.red;
        if (pix.green > top_next)
            top_next = pix.green;
        if (pix.blue > top_next)
            top_next = pix.blue;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pix.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1 capture and stage 2 differences plus reciprocal lookup
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red1_reg   <= pix.red;
            green1_reg <= pix.green;
            blue1_reg  <= pix.blue;
            top1_reg   <= top_next;
            dc2_reg    <= top1_reg - red1_reg;
            dm2_reg    <= top1_reg - green1_reg;
            dy2_reg    <= top1_reg - blue1_reg;
            dk2_reg    <= FULL_SCALE - top1_reg;
            top2_reg   <= top1_reg;
            recip2_reg <= RECIP_TBL[top1_reg];
        end
    end

    // stages 3 and 4: scaled shares; a black pixel falls out naturally
    rtcp_share u_cyan    (.clk(clk), .en(adv), .operand(dc2_reg),  .recip(recip2_reg),
                          .pct(cyan_w));
    rtcp_share u_magenta (.clk(clk), .en(adv), .operand(dm2_reg),  .recip(recip2_reg),
                          .pct(magenta_w));
    rtcp_share u_yellow  (.clk(clk), .en(adv), .operand(dy2_reg),  .recip(recip2_reg),
                          .pct(yellow_w));
    rtcp_share u_black   (.clk(clk), .en(adv), .operand(dk2_reg),  .recip(FULL_RECIP),
                          .pct(black_w));
    rtcp_share u_white   (.clk(clk), .en(adv), .operand(top2_reg), .recip(FULL_RECIP),
                          .pct(white_w));

    assign pct.valid       = v4_reg;
    assign pct.cyan_pct    = cyan_w;
    assign pct.magenta_pct = magenta_w;
    assign pct.yellow_pct  = yellow_w;
    assign pct.black_pct   = black_w;
    assign pct.white_pct   = white_w;

    // a request that meets no stall reaches the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready) ##1 adv ##1 adv ##1 adv |=> pct.valid)
        else $error("request lost in pipeline");

    // the largest channel always gives a zero share
    a_zero_share: assert property (@(posedge clk) disable iff (!rst_n)
        pct.valid |-> (pct.cyan_pct == '0 || pct.magenta_pct == '0 ||
                       pct.yellow_pct == '0))
        else $error("no zero colour share");

    // black and white split full scale, less at most one from truncation
    a_black_white: assert property (@(posedge clk) disable iff (!rst_n)
        pct.valid |-> ((16'(pct.black_pct) + 16'(pct.white_pct) == 16'd25600) ||
                       (16'(pct.black_pct) + 16'(pct.white_pct) == 16'd25599)))
        else $error("black and white do not sum to full scale");

    // shares stay within one hundred percent
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        pct.valid |-> (pct.cyan_pct <= 15'd25600 && pct.magenta_pct <= 15'd25600 &&
                       pct.yellow_pct <= 15'd25600))
        else $error("share above full scale");

endmodule

FILE: rtl/rtcp_share.sv
// rtcp_share: two-stage reciprocal multiply, floor(operand * recip >> 16)
// depends on rtcp_pkg
module rtcp_share (
    input  logic             clk,
    input  logic             en,
    input  rtcp_pkg::chan_t  operand,
    input  rtcp_pkg::recip_t recip,
    output rtcp_pkg::pct_t   pct
);
    import rtcp_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    pct_t              pct_reg;
    pct_t              pct_next;

    function automatic pct_t prod_next_sel(logic [PROD_W-1:0] p);
        return p[FRAC_SHIFT +: PCT_W];
    endfunction

    // multiply stage
    assign prod_next = PROD_W'(operand) * PROD_W'(recip);

    // drop fraction bits, result never exceeds 25600
    assign pct_next = prod_next_sel(prod_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            pct_reg  <= pct_next;
        end
    end

    assign pct = pct_reg;

endmodule

FILE: sim/cmyk_result_check.sv
// cmyk_result_check: watches the pixel and percentage channels, predicts each
// conversion and compares results in order
// depends on rtcp_pkg and rtcp_if
module cmyk_result_check (
    input  logic  clk,
    input  logic  rst_n,
    rtcp_pixel_if pix,
    rtcp_pct_if   pct,
    output int    mismatch_count,
    output int    pending_count,
    output int    result_count,
    output int    black_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import rtcp_pkg::*;

    typedef struct packed {
        pct_t cyan;
        pct_t magenta;
        pct_t yellow;
        pct_t black;
        pct_t white;
    } cmyk_pct_t;

    localparam int SHOWN_FAILS = 10;

    cmyk_pct_t cmyk_expected_q [$];

    // percentages for one pixel, truncated, 8 fraction bits
    function automatic cmyk_pct_t predict_cmyk(chan_t r, chan_t g, chan_t b);
        cmyk_pct_t   res;
        logic [31:0] top;
        logic [31:0] full;
        full = 32'(FULL_SCALE);
        top  = 32'(r);
        if (32'(g) > top)
            top = 32'(g);
        if (32'(b) > top)
            top = 32'(b);
        // black pixel has no divisor: solid black, no ink share, no white
        if (top == 32'd0)
        begin
            res       = '0;
            res.black = pct_t'(PCT_SCALE);
        end
        else
        begin
            res.cyan    = pct_t'(((top - 32'(r)) * PCT_SCALE) / top);
            res.magenta = pct_t'(((top - 32'(g)) * PCT_SCALE) / top);
            res.yellow  = pct_t'(((top - 32'(b)) * PCT_SCALE) / top);
            res.black   = pct_t'(((full - top) * PCT_SCALE) / full);
            res.white   = pct_t'((top * PCT_SCALE) / full);
        end
        return res;
    endfunction

    task automatic note_failure(input string what, input cmyk_pct_t want,
                                input cmyk_pct_t got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_FAILS)
        begin
            $display("%t: %s", $realtime, what);
            $display("    expected c=%0d m=%0d y=%0d k=%0d w=%0d",
                     want.cyan, want.magenta, want.yellow, want.black, want.white);
            $display("    actual   c=%0d m=%0d y=%0d k=%0d w=%0d",
                     got.cyan, got.magenta, got.yellow, got.black, got.white);
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
        result_count   = 0;
        black_count    = 0;
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin : watch
        cmyk_pct_t want;
        cmyk_pct_t got;
        if (rst_n)
        begin
            // finished result against the oldest prediction
            if (pct.valid && pct.ready)
            begin
                got = '{pct.cyan_pct, pct.magenta_pct, pct.yellow_pct,
                        pct.black_pct, pct.white_pct};
                result_count++;
                if (cmyk_expected_q.size() == 0)
                    note_failure("result with no request outstanding", '0, got);
                else
                begin
                    want = cmyk_expected_q.pop_front();
                    if (got !== want)
                        note_failure("percentage mismatch", want, got);
                end
            end
            // accepted request
            if (pix.valid && pix.ready)
            begin
                if (pix.red == '0 && pix.green == '0 && pix.blue == '0)
                    black_count++;
                cmyk_expected_q.push_back(predict_cmyk(pix.red, pix.green, pix.blue));
            end
            pending_count = cmyk_expected_q.size();
        end
    end

endmodule

FILE: sim/tb_rgb_to_cmyk_percent.sv
// tb_rgb_to_cmyk_percent: pixel stimulus, output back-pressure and verdict
// for the rgb to cmyk percentage converter
// depends on rtcp_pkg, rtcp_if, the converter rtl and cmyk_result_check
module tb_rgb_to_cmyk_percent;
    timeunit 1ns;
    timeprecision 1ps;

    import rtcp_pkg::*;

    localparam int PHASE_PIXELS = 345;
    localparam int SETTLE_CYCLES = 12;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   directed_sent;
    int   random_sent;
    int   mismatch_count;
    int   pending_count;
    int   result_count;
    int   black_count;

    rtcp_pixel_if pix ();
    rtcp_pct_if   pct ();

    rgb_to_cmyk_percent u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .pct   (pct)
    );

    cmyk_result_check u_result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix            (pix),
        .pct            (pct),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count),
        .black_count    (black_count)
    );

    // clock, 2 ns period
    initial
        clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // random back-pressure on the result side
    initial
    begin
        pct.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pct.ready = rst_n && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // one request, with random idle cycles in front of it
    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix.valid = 1'b0;
            pix.red   = chan_t'($urandom);
            pix.green = chan_t'($urandom);
            pix.blue  = chan_t'($urandom);
            @(negedge clk);
        end
        pix.valid = 1'b1;
        pix.red   = r;
        pix.green = g;
        pix.blue  = b;
        do
            @(posedge clk);
        while (!pix.ready);
        @(negedge clk);
    endtask

    // random pixel, biased towards ties, saturation, zeros and tiny values
    task automatic send_random_pixel();
        chan_t r;
        chan_t g;
        chan_t b;
        int    kind;
        r    = chan_t'($urandom);
        g    = chan_t'($urandom);
        b    = chan_t'($urandom);
        kind = $urandom_range(9);
        case (kind)
            6:
            begin
                r = chan_t'($urandom_range(3));
                g = chan_t'($urandom_range(3));
                b = chan_t'($urandom_range(3));
            end
            7:
            begin
                case ($urandom_range(2))
                    0: r = FULL_SCALE;
                    1: g = FULL_SCALE;
                    default: b = FULL_SCALE;
                endcase
            end
            8:
            begin
                g = r;
                if ($urandom_range(1) == 0)
                    b = r;
            end
            9:
            begin
                if ($urandom_range(1) == 0)
                    r = '0;
                if ($urandom_range(1) == 0)
                    g = '0;
                b = '0;
            end
            default:
            begin
            end
        endcase
        send_pixel(r, g, b);
        random_sent++;
    endtask

    // hold off until every outstanding request has produced its result
    task automatic drain();
        pix.valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic send_directed(input chan_t r, input chan_t g, input chan_t b);
        send_pixel(r, g, b);
        directed_sent++;
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        pix.valid     = 1'b0;
        pix.red       = '0;
        pix.green     = '0;
        pix.blue      = '0;
        src_idle_pct  = 15;
        sink_idle_pct = 61;
        directed_sent = 0;
        random_sent   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // corners: black, white, primaries, smallest divisors, bit patterns
        send_directed(8'd0,   8'd0,   8'd0);
        send_directed(8'd255, 8'd255, 8'd255);
        send_directed(8'd255, 8'd0,   8'd0);
        send_directed(8'd0,   8'd255, 8'd0);
        send_directed(8'd0,   8'd0,   8'd255);
        send_directed(8'd1,   8'd0,   8'd0);
        send_directed(8'd0,   8'd1,   8'd0);
        send_directed(8'd0,   8'd0,   8'd1);
        send_directed(8'd1,   8'd1,   8'd1);
        send_directed(8'd254, 8'd255, 8'd253);
        send_directed(8'd255, 8'd254, 8'd1);
        send_directed(8'd170, 8'd85,  8'd0);
        send_directed(8'd85,  8'd170, 8'd255);
        send_directed(8'd128, 8'd64,  8'd32);
        send_directed(8'd1,   8'd2,   8'd3);
        send_directed(8'd200, 8'd200, 8'd0);
        send_directed(8'd127, 8'd128, 8'd126);
        send_directed(8'd0,   8'd0,   8'd0);
        drain();

        // sender mostly busy, receiver often stalled
        repeat (PHASE_PIXELS) send_random_pixel();
        drain();

        // sender often idle, receiver mostly ready
        src_idle_pct  = 61;
        sink_idle_pct = 15;
        repeat (PHASE_PIXELS) send_random_pixel();
        drain();

        // full rate both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (PHASE_PIXELS) send_random_pixel();
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d pixels (%0d directed, %0d random, %0d all black)",
                 directed_sent + random_sent, directed_sent, random_sent, black_count);
        $display("%0d conversions compared across three idle/stall mixes, %0d mismatches",
                 result_count, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", pending_count);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rtcp_pkg.sv
rtl/rtcp_if.sv
rtl/rtcp_share.sv
rtl/rgb_to_cmyk_percent.sv
sim/cmyk_result_check.sv
sim/tb_rgb_to_cmyk_percent.sv
